// File: rtl/csr_spmv_pkg.sv
// Shared types and constants for the CSR sparse matrix-vector core.
// Used by every module in rtl/; depends on nothing else.
package csr_spmv_pkg;

    // Field widths of the request and result channels.
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 16;
    localparam int PROD_W   = 2 * VALUE_W;
    localparam int ACC_W    = 48;
    localparam int ROW_W    = 20;

    // Vector store geometry.
    localparam int VECTOR_DEPTH = 1024;
    localparam int VEC_AW       = $clog2(VECTOR_DEPTH);

    // Depth of the internal queues (power of two).
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Command codes on the request channel.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MAC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;

    // Saturation limits of the accumulator.
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Operation classes handed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_MAC,
        OP_CLOSE
    } t_op_kind;

    typedef struct packed {
        t_op_kind                   kind;
        logic [INDEX_W-1:0]         index;
        logic signed [VALUE_W-1:0]  value;
        logic                       row_end;
        logic                       in_range;
    } t_op;

    typedef struct packed {
        logic signed [ACC_W-1:0]    row_sum;
        logic [ROW_W-1:0]           row_number;
        logic                       saturated;
    } t_res;

endpackage

// File: rtl/csr_spmv_front.sv
// Front end: accepts requests, classifies the command and registers the operation.
// Depends on csr_spmv_pkg.
module csr_spmv_front (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        push,
    output logic                                        full,
    input  logic [csr_spmv_pkg::CMD_W-1:0]              i_command,
    input  logic [csr_spmv_pkg::INDEX_W-1:0]            i_index,
    input  logic signed [csr_spmv_pkg::VALUE_W-1:0]     i_value,
    input  logic                                        i_row_end,
    output logic                                        o_op_push,
    output csr_spmv_pkg::t_op                           o_op,
    input  logic                                        i_op_full
);
    import csr_spmv_pkg::*;

    logic   r_vld;
    t_op    r_op;
    logic   n_vld;
    t_op    n_op;
    logic   n_keep;
    logic   accept;

    // The holding register drains into the queue whenever the queue has room.
    assign o_op_push = r_vld && !i_op_full;
    assign full      = r_vld && i_op_full;
    assign accept    = push && !full;
    assign o_op      = r_op;

    // Classify the command; unused codes are dropped here.
    always_comb begin
        n_op.index    = i_index;
        n_op.value    = i_value;
        n_op.row_end  = i_row_end;
        n_op.in_range = (32'(i_index) < VECTOR_DEPTH);
        n_op.kind     = OP_LOAD;
        n_keep        = 1'b1;
        case (i_command)
            CMD_LOAD:  n_op.kind = OP_LOAD;
            CMD_MAC:   n_op.kind = OP_MAC;
            CMD_CLOSE: n_op.kind = OP_CLOSE;
            default:   n_keep    = 1'b0;
        endcase
    end

    // Next state of the holding register.
    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = n_keep;
        end else if (o_op_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= n_op;
        end
    end

endmodule

// File: rtl/csr_spmv_opq.sv
// Short operation queue that decouples the front end from the back end.
// Depends on csr_spmv_pkg.
module csr_spmv_opq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  csr_spmv_pkg::t_op   i_op,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output csr_spmv_pkg::t_op   o_op
);
    import csr_spmv_pkg::*;

    t_op                r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = r_entry[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_op;
        end
    end

endmodule

// File: rtl/csr_spmv_back.sv
// Back end: vector store, multiplier, saturating row accumulator and result queue.
// Depends on csr_spmv_pkg.
module csr_spmv_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_op_empty,
    input  csr_spmv_pkg::t_op   i_op,
    output logic                o_op_pop,
    output logic                empty,
    input  logic                pop,
    output csr_spmv_pkg::t_res  o_res
);
    import csr_spmv_pkg::*;

    // Vector store and its registered read data.
    logic [VALUE_W-1:0]         r_vec [VECTOR_DEPTH];
    logic [VALUE_W-1:0]         r_rd_data;

    // Stage 1: operation read from the queue.
    logic                       r1_vld;
    t_op_kind                   r1_kind;
    logic signed [VALUE_W-1:0]  r1_value;
    logic                       r1_row_end;
    logic                       r1_in_range;

    // Stage 2: product.
    logic                       r2_vld;
    t_op_kind                   r2_kind;
    logic                       r2_row_end;
    logic signed [PROD_W-1:0]   r2_prod;

    // Row state.
    logic signed [ACC_W-1:0]    r_acc;
    logic [ROW_W-1:0]           r_row;
    logic                       r_clip;

    // Result queue.
    t_res                       r_rq [QUEUE_DEPTH];
    logic [QPTR_W-1:0]          r_rq_wr;
    logic [QPTR_W-1:0]          r_rq_rd;
    logic [QCNT_W-1:0]          r_rq_cnt;

    logic                       advance;
    logic                       n1_vld;
    logic signed [VALUE_W-1:0]  x_sel;
    logic signed [PROD_W-1:0]   n_prod;
    logic signed [ACC_W:0]      sum_wide;
    logic signed [ACC_W-1:0]    sum_sat;
    logic                       sum_clip;
    logic                       emit;
    t_res                       n_res;
    logic                       rq_pop;

    // The whole pipeline moves only while the result queue has room.
    assign advance  = (r_rq_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_op_pop = advance && !i_op_empty;
    assign n1_vld   = o_op_pop && (i_op.kind != OP_LOAD);

    // Vector store: loads write, nonzeros read with registered data.
    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            if (i_op.kind == OP_LOAD && i_op.in_range) begin
                r_vec[i_op.index[VEC_AW-1:0]] <= i_op.value;
            end
            r_rd_data <= r_vec[i_op.index[VEC_AW-1:0]];
        end
    end

    // Multiply the nonzero by its vector entry; columns out of range read zero.
    assign x_sel  = r1_in_range ? $signed(r_rd_data) : '0;
    assign n_prod = r1_value * x_sel;

    // Saturating accumulation of the current product.
    always_comb begin
        sum_wide = {r_acc[ACC_W-1], r_acc} + (ACC_W+1)'(r2_prod);
        sum_clip = (sum_wide[ACC_W] != sum_wide[ACC_W-1]);
        if (!sum_clip) begin
            sum_sat = sum_wide[ACC_W-1:0];
        end else if (sum_wide[ACC_W]) begin
            sum_sat = ACC_MIN;
        end else begin
            sum_sat = ACC_MAX;
        end
    end

    // A row closes on a nonzero with its end mark or on a close request.
    always_comb begin
        emit             = 1'b0;
        n_res.row_number = r_row;
        n_res.row_sum    = r_acc;
        n_res.saturated  = r_clip;
        if (r2_vld) begin
            case (r2_kind)
                OP_MAC: begin
                    emit            = r2_row_end;
                    n_res.row_sum   = sum_sat;
                    n_res.saturated = r_clip || sum_clip;
                end
                OP_CLOSE: begin
                    emit = 1'b1;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // Pipeline valid bits and row state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r_acc  <= '0;
            r_row  <= '0;
            r_clip <= 1'b0;
        end else if (advance) begin
            r1_vld <= n1_vld;
            r2_vld <= r1_vld;
            if (emit) begin
                r_acc  <= '0;
                r_clip <= 1'b0;
                r_row  <= r_row + 1'b1;
            end else if (r2_vld && r2_kind == OP_MAC) begin
                r_acc  <= sum_sat;
                r_clip <= r_clip || sum_clip;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_kind     <= i_op.kind;
            r1_value    <= i_op.value;
            r1_row_end  <= i_op.row_end;
            r1_in_range <= i_op.in_range;
            r2_kind     <= r1_kind;
            r2_row_end  <= r1_row_end;
            r2_prod     <= n_prod;
        end
    end

    // Result queue toward the consumer.
    assign empty  = (r_rq_cnt == '0);
    assign rq_pop = pop && !empty;
    assign o_res  = r_rq[r_rq_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wr  <= '0;
            r_rq_rd  <= '0;
            r_rq_cnt <= '0;
        end else begin
            if (advance && emit) begin
                r_rq_wr <= r_rq_wr + 1'b1;
            end
            if (rq_pop) begin
                r_rq_rd <= r_rq_rd + 1'b1;
            end
            if (advance && emit && !rq_pop) begin
                r_rq_cnt <= r_rq_cnt + 1'b1;
            end else if (rq_pop && !(advance && emit)) begin
                r_rq_cnt <= r_rq_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_rq[r_rq_wr] <= n_res;
        end
    end

endmodule

// File: rtl/csr_sparse_matvec_core.sv
// Top level of the CSR sparse matrix-vector core.
// Depends on csr_spmv_pkg, csr_spmv_front, csr_spmv_opq and csr_spmv_back.
//
// Usage:
//   Requests enter through a queue-like port: a request is taken at a clock edge
//   where push is high and full is low. Command 0 loads a vector entry, command 1
//   is a matrix nonzero (row_end closes its row), command 2 closes the open row.
//   Results leave through a queue-like port: while empty is low the oldest row
//   result is on the result ports, and it is taken when pop is high.
// Throughput and data path:
//   One request per cycle is sustained while pop keeps the result queue from filling.
//   A row result passes the front register, operation queue, vector store read
//   and multiplier before the accumulator writes it into the result queue. The
//   accumulator feedback loop, one 48-bit add with saturation per cycle, sets the rate.
// Reset:
//   Synchronous, active low. Queues, the accumulator, the clip flag and the row
//   counter clear; the vector store keeps its contents and must be loaded first.
// Stalls:
//   When pop stays low the four-entry result queue fills, the back end halts,
//   the operation queue fills and full rises; no request or result is lost.
module csr_sparse_matvec_core (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        push,
    output logic                                        full,
    input  logic [csr_spmv_pkg::CMD_W-1:0]              i_command,
    input  logic [csr_spmv_pkg::INDEX_W-1:0]            i_index,
    input  logic signed [csr_spmv_pkg::VALUE_W-1:0]     i_value,
    input  logic                                        i_row_end,
    output logic                                        empty,
    input  logic                                        pop,
    output logic signed [csr_spmv_pkg::ACC_W-1:0]       o_row_sum,
    output logic [csr_spmv_pkg::ROW_W-1:0]              o_row_number,
    output logic                                        o_saturated
);
    import csr_spmv_pkg::*;

    logic   op_push;
    logic   op_full;
    logic   op_pop;
    logic   op_empty;
    t_op    front_op;
    t_op    queue_op;
    t_res   res;

    // Front end: request acceptance and classification.
    csr_spmv_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_command (i_command),
        .i_index   (i_index),
        .i_value   (i_value),
        .i_row_end (i_row_end),
        .o_op_push (op_push),
        .o_op      (front_op),
        .i_op_full (op_full)
    );

    // Operation queue between the two halves.
    csr_spmv_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_op    (front_op),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_empty (op_empty),
        .o_op    (queue_op)
    );

    // Back end: vector store, multiply-accumulate and result queue.
    csr_spmv_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_empty (op_empty),
        .i_op       (queue_op),
        .o_op_pop   (op_pop),
        .empty      (empty),
        .pop        (pop),
        .o_res      (res)
    );

    assign o_row_sum    = res.row_sum;
    assign o_row_number = res.row_number;
    assign o_saturated  = res.saturated;

endmodule

// File: dv/tb_csr_sparse_matvec_core.sv
// Self-checking testbench for csr_sparse_matvec_core: vector loads, nonzeros and row closes
// are checked against a cycle-free row predictor. Depends on csr_spmv_pkg and the core RTL.
module tb_csr_sparse_matvec_core;
    import csr_spmv_pkg::*;

    // Command code that the core must ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int     RANDOM_ITEMS = 1100;
    localparam int     LONG_ROW_LEN = 40;
    localparam int     QUIET_LIMIT  = 2000;
    localparam int     HOLD_CYCLES  = 200;
    localparam longint SUM_CEIL     = longint'(ACC_MAX);
    localparam longint SUM_FLOOR    = longint'(ACC_MIN);

    typedef struct {
        logic [CMD_W-1:0]          command;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
        logic                      row_end;
        bit                        drain;
        bit                        no_gap;
    } spmv_req_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic [CMD_W-1:0]           i_command = CMD_LOAD;
    logic [INDEX_W-1:0]         i_index = '0;
    logic signed [VALUE_W-1:0]  i_value = '0;
    logic                       i_row_end = 1'b0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic signed [ACC_W-1:0]    o_row_sum;
    logic [ROW_W-1:0]           o_row_number;
    logic                       o_saturated;

    csr_sparse_matvec_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_command    (i_command),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_row_end    (i_row_end),
        .empty        (empty),
        .pop          (pop),
        .o_row_sum    (o_row_sum),
        .o_row_number (o_row_number),
        .o_saturated  (o_saturated)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Requests waiting to be offered, and row results that the core still owes.
    spmv_req_t  req_backlog[$];
    t_res       row_results_due[$];
    int         mismatches = 0;
    int         rows_predicted = 0;
    int         rows_checked = 0;

    // Predictor state: its own copy of the vector store and the row registers.
    logic signed [VALUE_W-1:0] vec_model[VECTOR_DEPTH];
    longint                    acc_model = 0;
    logic [ROW_W-1:0]          row_model = '0;
    bit                        clip_model = 1'b0;

    // Generator bookkeeping: only loaded columns may be read by a nonzero.
    bit  col_loaded[VECTOR_DEPTH];
    int  written_cols[$];
    bit  drain_next = 1'b0;
    bit  no_gap_phase = 1'b0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Applies one request to the predictor; returns 1 when it closes a row.
    function automatic bit predict_row_result(input spmv_req_t r, output t_res res);
        longint sum;
        bit     closes;
        closes = 1'b0;
        res = '0;
        case (r.command)
            CMD_LOAD: begin
                vec_model[r.index] = r.value;
            end
            CMD_MAC: begin
                sum = acc_model + longint'(r.value) * longint'(vec_model[r.index]);
                if (sum > SUM_CEIL) begin
                    sum = SUM_CEIL;
                    clip_model = 1'b1;
                end else if (sum < SUM_FLOOR) begin
                    sum = SUM_FLOOR;
                    clip_model = 1'b1;
                end
                acc_model = sum;
                closes = r.row_end;
            end
            CMD_CLOSE: begin
                closes = 1'b1;
            end
            default: begin
            end
        endcase
        if (closes) begin
            res.row_sum    = acc_model[ACC_W-1:0];
            res.row_number = row_model;
            res.saturated  = clip_model;
            acc_model  = 0;
            clip_model = 1'b0;
            row_model  = row_model + 1'b1;
        end
        return closes;
    endfunction

    task automatic queue_req(input logic [CMD_W-1:0] cmd, input int idx,
                             input logic [VALUE_W-1:0] val, input bit re);
        spmv_req_t r;
        r.command = cmd;
        r.index   = idx[INDEX_W-1:0];
        r.value   = val;
        r.row_end = re;
        r.drain   = drain_next;
        r.no_gap  = no_gap_phase;
        drain_next = 1'b0;
        if (cmd == CMD_LOAD && !col_loaded[idx]) begin
            col_loaded[idx] = 1'b1;
            written_cols.push_back(idx);
        end
        req_backlog.push_back(r);
    endtask

    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] extremes[4];
        extremes = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        if ($urandom_range(0, 7) == 0)
            return extremes[$urandom_range(0, 3)];
        return VALUE_W'($urandom);
    endfunction

    function automatic int rand_column();
        return written_cols[$urandom_range(0, written_cols.size() - 1)];
    endfunction

    // Mostly well-formed rows with random content, plus loads, empty rows,
    // rows cut short by a close, and ignored commands.
    task automatic gen_random_traffic(input int n_items);
        int counted;
        int len;
        int pick;
        counted = 0;
        while (counted < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                drain_next = 1'b1;
            if (pick < 60) begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    queue_req(CMD_MAC, rand_column(), rand_value(), k == len - 1);
                counted += len;
            end else if (pick < 72) begin
                queue_req(CMD_LOAD, $urandom_range(0, VECTOR_DEPTH - 1), rand_value(),
                          1'($urandom_range(0, 1)));
                counted++;
            end else if (pick < 80) begin
                queue_req(CMD_CLOSE, $urandom_range(0, VECTOR_DEPTH - 1), rand_value(),
                          1'($urandom_range(0, 1)));
                counted++;
            end else if (pick < 93) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    queue_req(CMD_MAC, rand_column(), rand_value(), 1'b0);
                queue_req(CMD_CLOSE, $urandom_range(0, VECTOR_DEPTH - 1), rand_value(),
                          1'($urandom_range(0, 1)));
                counted += len + 1;
            end else begin
                queue_req(CMD_UNUSED, $urandom_range(0, VECTOR_DEPTH - 1), rand_value(),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    // One long row of identical extreme products, driven back to back.
    task automatic queue_long_row(input logic [VALUE_W-1:0] vec_val,
                                  input logic [VALUE_W-1:0] nz_val);
        drain_next = 1'b1;
        no_gap_phase = 1'b1;
        queue_req(CMD_LOAD, 'h200, vec_val, 1'b0);
        for (int k = 0; k < LONG_ROW_LEN; k++)
            queue_req(CMD_MAC, 'h200, nz_val, 1'b0);
        // A small product closes the row.
        queue_req(CMD_MAC, 'h200, 16'h0001, 1'b1);
        no_gap_phase = 1'b0;
    endtask

    // Request driver: offers the backlog and runs the predictor on every accepted request.
    spmv_req_t cur_req;
    int        send_gap = 0;
    bit        send_burst = 1'b0;

    always @(posedge i_clk) begin
        t_res res;
        bit   offering;
        if (!i_rst_n) begin
            push <= 1'b0;
            send_gap = 0;
        end else begin
            offering = push;
            if (push && !full) begin
                offering = 1'b0;
                if (predict_row_result(cur_req, res)) begin
                    row_results_due.push_back(res);
                    rows_predicted++;
                end
                send_gap = (cur_req.no_gap || send_burst) ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 63) == 0)
                    send_burst = !send_burst;
            end
            if (!offering) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (req_backlog.size() != 0 &&
                             !(req_backlog[0].drain && rows_predicted != rows_checked)) begin
                    cur_req = req_backlog.pop_front();
                    offering = 1'b1;
                    i_command <= cur_req.command;
                    i_index   <= cur_req.index;
                    i_value   <= cur_req.value;
                    i_row_end <= cur_req.row_end;
                end
            end
            push <= offering;
        end
    end

    // Result monitor: pops with random stalls, one long hold-off, and checks each row.
    int  take_gap = 0;
    int  hold_left = 0;
    int  rows_seen = 0;
    bit  held_off = 1'b0;
    bit  take_burst = 1'b0;

    always @(posedge i_clk) begin
        t_res want;
        bit   ready;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            ready = pop;
            if (pop && !empty) begin
                ready = 1'b0;
                rows_seen++;
                if (row_results_due.size() == 0) begin
                    report_mismatch($sformatf("row %0d arrived with no row pending",
                                              o_row_number));
                end else begin
                    want = row_results_due.pop_front();
                    if (o_row_sum !== want.row_sum)
                        report_mismatch($sformatf("row %0d sum %0d, want %0d",
                                                  want.row_number, o_row_sum, want.row_sum));
                    if (o_row_number !== want.row_number)
                        report_mismatch($sformatf("row number %0d, want %0d",
                                                  o_row_number, want.row_number));
                    if (o_saturated !== want.saturated)
                        report_mismatch($sformatf("row %0d saturated %b, want %b",
                                                  want.row_number, o_saturated,
                                                  want.saturated));
                    rows_checked <= rows_checked + 1;
                end
                take_gap = take_burst ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 31) == 0)
                    take_burst = !take_burst;
                if (!held_off && rows_seen >= 100) begin
                    held_off = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            if (!ready) begin
                if (hold_left != 0)
                    hold_left--;
                else if (take_gap != 0)
                    take_gap--;
                else
                    ready = 1'b1;
            end
            pop <= ready;
        end
    end

    // Watchdog on cycles in which neither side moves a request or a result.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // Directed requests: field extremes, index bit patterns, every command.
        queue_req(CMD_LOAD, 0, 16'h7FFF, 1'b0);
        queue_req(CMD_LOAD, 1023, 16'h8000, 1'b1);
        queue_req(CMD_LOAD, 'h155, 16'h5555, 1'b0);
        queue_req(CMD_LOAD, 'h2AA, 16'hAAAA, 1'b0);
        queue_req(CMD_LOAD, 1, 16'hFFFF, 1'b0);
        queue_req(CMD_MAC, 0, 16'h7FFF, 1'b0);
        queue_req(CMD_MAC, 1023, 16'h8000, 1'b1);
        queue_req(CMD_CLOSE, 0, 16'h0000, 1'b0);
        queue_req(CMD_CLOSE, 1023, 16'hFFFF, 1'b1);
        queue_req(CMD_MAC, 'h155, 16'h0001, 1'b0);
        queue_req(CMD_MAC, 'h2AA, 16'hFFFF, 1'b0);
        // A close in the middle of a row emits the unfinished row.
        queue_req(CMD_CLOSE, 'h2AA, 16'h5555, 1'b0);
        queue_req(CMD_UNUSED, 1023, 16'hFFFF, 1'b1);
        queue_req(CMD_MAC, 1, 16'h8000, 1'b1);
        queue_req(CMD_MAC, 0, 16'h0000, 1'b1);
        queue_req(CMD_LOAD, 0, 16'h0100, 1'b0);
        queue_req(CMD_MAC, 0, 16'h0100, 1'b1);
        queue_req(CMD_UNUSED, 0, 16'h0000, 1'b0);
        queue_req(CMD_CLOSE, 0, 16'h0000, 1'b0);

        drain_next = 1'b1;
        gen_random_traffic(RANDOM_ITEMS);

        // Long rows of extreme positive and negative products, then ordinary rows.
        queue_long_row(16'h8000, 16'h8000);
        queue_long_row(16'h8000, 16'h7FFF);
        drain_next = 1'b1;
        gen_random_traffic(60);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (req_backlog.size() != 0 || push || rows_predicted != rows_checked);
        repeat (20) @(negedge i_clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
